// ----- hdl/text_glyph_quad_generator_top_defines.svh -----
// Assertion macros used by the glyph quad generator datapath.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TEXT_GLYPH_QUAD_GENERATOR_TOP_DEFINES_SVH
`define TEXT_GLYPH_QUAD_GENERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGQG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGQG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tgqg_pkg.sv -----
// Package for the glyph quad generator: types, register indexes and font ROM.
// Used by the controller, the datapath and the top level.
package tgqg_pkg;

  localparam int COORD_W  = 20;
  localparam int PIX_W    = 12;
  localparam int COUNT_W  = 16;
  localparam int GLYPH_W  = 35;
  localparam int GLYPH_N  = 41;

  typedef logic [GLYPH_W-1:0] glyph_t;

  localparam logic [1:0] REG_PIXEL_SIZE = 2'd0;
  localparam logic [1:0] REG_DOT_SIZE   = 2'd1;
  localparam logic [1:0] REG_MAX_QUADS  = 2'd2;
  localparam logic [1:0] REG_QUAD_COLOR = 2'd3;

  localparam logic OP_DRAW  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic [2:0] LAST_COL = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic has_dots;
    logic done;
    logic out_blocked;
  } stat_t;

  // Rows top to bottom, row 0 in the upper five bits, leftmost column first.
  localparam glyph_t FONT_ROM [GLYPH_N] = '{
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C},
    {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
    {5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00},
    {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
    {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
    {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
  };

  // Returns the dot pattern of a character, all zero when it has no glyph.
  function automatic glyph_t glyph_lookup(logic [7:0] c);
    logic [7:0] u;
    logic [7:0] d;
    logic [5:0] slot;
    glyph_t     g;
    u = c;
    if (c inside {[8'h61:8'h7A]}) begin
      u = c - 8'd32;
    end
    slot = 6'd0;
    g    = '0;
    case (u)
      8'h20: g = FONT_ROM[0];
      8'h2E: g = FONT_ROM[1];
      8'h3A: g = FONT_ROM[2];
      8'h2D: g = FONT_ROM[3];
      8'h2F: g = FONT_ROM[4];
      default: begin
        if (u inside {[8'h30:8'h39]}) begin
          d    = u - 8'h30;
          slot = 6'd5 + d[5:0];
          g    = FONT_ROM[slot];
        end else if (u inside {[8'h41:8'h5A]}) begin
          d    = u - 8'h41;
          slot = 6'd15 + d[5:0];
          g    = FONT_ROM[slot];
        end
      end
    endcase
    return g;
  endfunction

endpackage

// ----- hdl/tgqg_ctrl.sv -----
// Controller of the glyph quad generator: idle and dot-scan states.
// Depends on tgqg_pkg; drives the datapath through cmd_t and reads stat_t.
module tgqg_ctrl
  import tgqg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.has_dots) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = !stat.out_blocked;
        if (cmd.step && stat.done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/tgqg_datapath.sv -----
// Datapath of the glyph quad generator: registers, cursor, dot scan and result register.
// Depends on tgqg_pkg and the assertion macros in text_glyph_quad_generator_top_defines.svh.
`include "text_glyph_quad_generator_top_defines.svh"

module tgqg_datapath
  import tgqg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      op,
  input  logic [7:0]                ch,
  input  logic                      first_char,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] left,
  output logic signed [COORD_W-1:0] top,
  output logic signed [COORD_W-1:0] right,
  output logic signed [COORD_W-1:0] bottom,
  output logic [COUNT_W-1:0]        quad_index,
  output logic                      last_quad
);

  logic [PIX_W-1:0]   pixel_size;
  logic [PIX_W-1:0]   dot_size;
  logic [COUNT_W-1:0] max_quads;

  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;
  logic [COORD_W-1:0] line_start_x;
  logic [COUNT_W-1:0] quad_count;

  glyph_t             glyph;
  logic [COORD_W-1:0] row_x;
  logic [COORD_W-1:0] dot_x;
  logic [COORD_W-1:0] dot_y;
  logic [2:0]         col;

  logic [COORD_W-1:0] pix_ext;
  logic [COORD_W-1:0] dot_ext;
  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;
  logic [COORD_W-1:0] line_x;
  glyph_t             in_glyph;
  logic [COUNT_W:0]   count_inc;
  logic               room;
  logic               emit;
  logic               rest_empty;
  logic               emit_last;

  assign pix_ext  = {{(COORD_W-PIX_W){1'b0}}, pixel_size};
  assign dot_ext  = {{(COORD_W-PIX_W){1'b0}}, dot_size};
  assign base_x   = first_char ? start_x : cursor_x;
  assign base_y   = first_char ? start_y : cursor_y;
  assign line_x   = first_char ? start_x : line_start_x;
  assign in_glyph = glyph_lookup(ch);

  assign count_inc  = {1'b0, quad_count} + {{COUNT_W{1'b0}}, 1'b1};
  assign room       = quad_count < max_quads;
  assign emit       = glyph[GLYPH_W-1] && room;
  assign rest_empty = (glyph[GLYPH_W-2:0] == '0);
  assign emit_last  = emit && (rest_empty || (count_inc >= {1'b0, max_quads}));

  assign stat.has_dots    = (op == OP_DRAW) && (ch != CH_NEWLINE) && (in_glyph != '0);
  assign stat.done        = rest_empty || emit_last || !room;
  assign stat.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_size <= 12'd16;
      dot_size   <= 12'd14;
      max_quads  <= 16'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_SIZE: pixel_size <= cfg_data[PIX_W-1:0];
        REG_DOT_SIZE:   dot_size   <= cfg_data[PIX_W-1:0];
        REG_MAX_QUADS:  max_quads  <= cfg_data[COUNT_W-1:0];
        REG_QUAD_COLOR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
      quad_count   <= '0;
    end else if (cmd.load) begin
      if (op == OP_CLEAR) begin
        quad_count <= '0;
      end else begin
        line_start_x <= line_x;
        if (ch == CH_NEWLINE) begin
          cursor_x <= line_x;
          cursor_y <= base_y + {pix_ext[COORD_W-4:0], 3'b000};
        end else begin
          cursor_x <= base_x + {pix_ext[COORD_W-2:0], 1'b0} + {pix_ext[COORD_W-3:0], 2'b00};
          cursor_y <= base_y;
        end
      end
    end else if (cmd.step && emit) begin
      quad_count <= count_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph <= in_glyph;
      row_x <= base_x;
      dot_x <= base_x;
      dot_y <= base_y;
      col   <= '0;
    end else if (cmd.step) begin
      glyph <= {glyph[GLYPH_W-2:0], 1'b0};
      if (col == LAST_COL) begin
        col   <= '0;
        dot_x <= row_x;
        dot_y <= dot_y + pix_ext;
      end else begin
        col   <= col + 3'd1;
        dot_x <= dot_x + pix_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      left       <= dot_x;
      top        <= dot_y;
      right      <= dot_x + dot_ext;
      bottom     <= dot_y + dot_ext;
      quad_index <= quad_count;
      last_quad  <= emit_last;
    end
  end

  `TGQG_ASSERT_SAME(a_col_range, cmd.step, col <= LAST_COL, "column counter out of range")
  `TGQG_ASSERT_NEXT(a_emit_shows, cmd.step && emit, out_valid && (quad_index == $past(quad_count)), "emitted quad not presented")
  `TGQG_ASSERT_SAME(a_last_ends, cmd.step && emit_last, stat.done, "scan continues after last quad")
  `TGQG_ASSERT_SAME(a_no_overwrite, cmd.step, !(out_valid && out_stall), "scan advanced while result stalled")

endmodule

// ----- hdl/text_glyph_quad_generator_top.sv -----
// Top level of the 5x7 glyph quad generator.
// Depends on tgqg_pkg, tgqg_ctrl and tgqg_datapath.
//
//   Channel   Handshake              Carries
//   input     in_valid / in_stall    op, ch, first_char, start_x, start_y
//   output    out_valid / out_stall  left, top, right, bottom, quad_index, last_quad
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A clear, a newline or a character without dots is taken without a scan.
// A character with dots is loaded, then its font bits are scanned in order;
// the scan ends at the last set dot, at the dot that fills the
// batch, or at the first bit when the batch is already full.
// Reset clears the cursor, line start and quad count and loads register defaults.
// While a result is stalled the scan holds; a new item is taken once the scan ends.
module text_glyph_quad_generator_top
  import tgqg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [7:0]                ch,
  input  logic                      first_char,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] left,
  output logic signed [COORD_W-1:0] top,
  output logic signed [COORD_W-1:0] right,
  output logic signed [COORD_W-1:0] bottom,
  output logic [COUNT_W-1:0]        quad_index,
  output logic                      last_quad,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tgqg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tgqg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .ch         (ch),
    .first_char (first_char),
    .start_x    (start_x),
    .start_y    (start_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left       (left),
    .top        (top),
    .right      (right),
    .bottom     (bottom),
    .quad_index (quad_index),
    .last_quad  (last_quad)
  );

endmodule

// ----- bench/text_glyph_quad_generator_top_test.sv -----
// Self-checking bench for the 5x7 glyph quad generator: a directed table, then random
// text strings under several register settings, checked against a behavioral font scan.
// Depends on tgqg_pkg and the text_glyph_quad_generator_top RTL.
module text_glyph_quad_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tgqg_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COUNT_W-1:0] quad_index;
    logic               last_quad;
  } glyph_quad_t;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         reg_index;
    logic [31:0]        reg_value;
    logic               op;
    logic [7:0]         ch;
    logic               first;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    bit                 typed;
    int                 n_typed;
    glyph_quad_t        first_quad;
  } plan_row_t;

  localparam logic [34:0] GLYPH_DOTS [41] = '{
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C},
    {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
    {5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00},
    {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
    {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
    {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
  };

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic                      op         = OP_DRAW;
  logic [7:0]                ch         = 8'h00;
  logic                      first_char = 1'b0;
  logic signed [COORD_W-1:0] start_x    = '0;
  logic signed [COORD_W-1:0] start_y    = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic [COORD_W-1:0]        left;
  logic [COORD_W-1:0]        top;
  logic [COORD_W-1:0]        right;
  logic [COORD_W-1:0]        bottom;
  logic [COUNT_W-1:0]        quad_index;
  logic                      last_quad;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index  = REG_PIXEL_SIZE;
  logic [31:0]               cfg_data   = '0;

  logic [COORD_W-1:0] pen_x       = '0;
  logic [COORD_W-1:0] pen_y       = '0;
  logic [COORD_W-1:0] margin_x    = '0;
  logic [COUNT_W-1:0] batch_count = '0;
  logic [PIX_W-1:0]   pitch       = 12'd16;
  logic [PIX_W-1:0]   dot_len     = 12'd14;
  logic [COUNT_W-1:0] batch_cap   = 16'd1024;

  glyph_quad_t pending_quads[$];
  glyph_quad_t head;
  plan_row_t   plan[$];
  int          errors      = 0;
  int          cycle_count = 0;
  int          hold_left   = 0;
  bit          calm        = 1'b0;
  logic        hold_req    = 1'b0;

  text_glyph_quad_generator_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int render_glyph(logic op_i, logic [7:0] ch_i, logic first_i,
                                      logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
    logic [7:0]  c;
    logic [34:0] dots;
    glyph_quad_t q;
    int          slot;
    int          n;
    int          r;
    int          col;
    n = 0;
    if (op_i == OP_CLEAR) begin
      batch_count = '0;
      return 0;
    end
    if (first_i) begin
      pen_x    = sx;
      pen_y    = sy;
      margin_x = sx;
    end
    if (ch_i == CH_NEWLINE) begin
      pen_x = margin_x;
      pen_y = pen_y + COORD_W'(8 * pitch);
      return 0;
    end
    c = (ch_i >= "a" && ch_i <= "z") ? ch_i - 8'd32 : ch_i;
    case (c)
      " ": slot = 0;
      ".": slot = 1;
      ":": slot = 2;
      "-": slot = 3;
      "/": slot = 4;
      default: begin
        if (c >= "0" && c <= "9") begin
          slot = 5 + c - "0";
        end else if (c >= "A" && c <= "Z") begin
          slot = 15 + c - "A";
        end else begin
          slot = -1;
        end
      end
    endcase
    if (slot >= 0) begin
      dots = GLYPH_DOTS[slot];
      for (r = 0; r < 7; r++) begin
        for (col = 0; col < 5; col++) begin
          if (dots[34 - 5 * r - col] && batch_count < batch_cap) begin
            q.left       = pen_x + COORD_W'(col * pitch);
            q.top        = pen_y + COORD_W'(r * pitch);
            q.right      = q.left + COORD_W'(dot_len);
            q.bottom     = q.top + COORD_W'(dot_len);
            q.quad_index = batch_count;
            q.last_quad  = 1'b0;
            pending_quads = {pending_quads, q};
            batch_count++;
            n++;
          end
        end
      end
      if (n > 0) begin
        pending_quads[pending_quads.size() - 1].last_quad = 1'b1;
      end
    end
    pen_x = pen_x + COORD_W'(6 * pitch);
    return n;
  endfunction

  function automatic plan_row_t item_row(logic op_i, logic [7:0] ch_i, logic first_i,
                                         logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
    plan_row_t row;
    row        = '{default: '0};
    row.op     = op_i;
    row.ch     = ch_i;
    row.first  = first_i;
    row.sx     = sx;
    row.sy     = sy;
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic op_i, logic [7:0] ch_i, logic first_i,
                                          logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                          int n, int l, int t, int r, int b, int idx);
    plan_row_t row;
    row            = item_row(op_i, ch_i, first_i, sx, sy);
    row.typed      = 1'b1;
    row.n_typed    = n;
    row.first_quad = '{COORD_W'(l), COORD_W'(t), COORD_W'(r), COORD_W'(b),
                       COUNT_W'(idx), 1'b0};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [1:0] idx, logic [31:0] value);
    plan_row_t row;
    row           = '{default: '0};
    row.is_cfg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  function automatic void append_row(plan_row_t row);
    plan = {plan, row};
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic put_item(logic op_i, logic [7:0] ch_i, logic first_i,
                          logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy, output int n);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 21);
    end
    in_valid   <= 1'b1;
    op         <= op_i;
    ch         <= ch_i;
    first_char <= first_i;
    start_x    <= sx;
    start_y    <= sy;
    do @(posedge clk); while (in_stall);
    n = render_glyph(op_i, ch_i, first_i, sx, sy);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_quads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PIXEL_SIZE: pitch     = value[PIX_W-1:0];
      REG_DOT_SIZE:   dot_len   = value[PIX_W-1:0];
      REG_MAX_QUADS:  batch_cap = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_glyph_quad_generator_top test failed");
      $finish;
    end
  end

  // The long hold lets the block fill up and stall its input channel.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_quads.size() == 0) begin
        $error("quad with no expectation waiting: left %0h top %0h index %0h",
               left, top, quad_index);
        errors++;
      end else begin
        head = pending_quads.pop_front();
        check_field("left", 32'(head.left), 32'(left));
        check_field("top", 32'(head.top), 32'(top));
        check_field("right", 32'(head.right), 32'(right));
        check_field("bottom", 32'(head.bottom), 32'(bottom));
        check_field("quad_index", 32'(head.quad_index), 32'(quad_index));
        check_field("last_quad", 32'(head.last_quad), 32'(last_quad));
      end
    end
  end

  initial begin
    int                 n;
    int                 pos;
    int unsigned        ph;
    int unsigned        k;
    int unsigned        pick;
    bit                 in_string;
    logic [PIX_W-1:0]   p;
    logic [PIX_W-1:0]   d;
    logic [COUNT_W-1:0] m;
    logic [31:0]        c;
    logic               rop;
    logic               rfirst;
    logic [7:0]         rch;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    string              charset;
    charset = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz .:-/";

    append_row(typed_row(OP_DRAW, ".", 1'b0, 20'h12345, 20'h54321,
                         4, 16, 80, 30, 94, 0));
    append_row(item_row(OP_DRAW, "-", 1'b0, 20'h00000, 20'h00000));
    append_row(typed_row(OP_DRAW, CH_NEWLINE, 1'b0, 20'hFFFFF, 20'hFFFFF,
                         0, 0, 0, 0, 0, 0));
    append_row(item_row(OP_DRAW, "A", 1'b0, 20'h00000, 20'h00000));
    append_row(item_row(OP_DRAW, "a", 1'b0, 20'h00000, 20'h00000));
    append_row(typed_row(OP_DRAW, 8'h00, 1'b0, 20'h00000, 20'h00000,
                         0, 0, 0, 0, 0, 0));
    append_row(typed_row(OP_DRAW, 8'hFF, 1'b0, 20'h00000, 20'h00000,
                         0, 0, 0, 0, 0, 0));
    append_row(typed_row(OP_DRAW, " ", 1'b0, 20'h00000, 20'h00000,
                         0, 0, 0, 0, 0, 0));
    append_row(item_row(OP_DRAW, ":", 1'b0, 20'h00000, 20'h00000));
    append_row(item_row(OP_DRAW, "/", 1'b0, 20'h00000, 20'h00000));
    append_row(item_row(OP_DRAW, "0", 1'b0, 20'h00000, 20'h00000));
    append_row(item_row(OP_DRAW, "9", 1'b0, 20'h00000, 20'h00000));
    append_row(item_row(OP_DRAW, "Z", 1'b0, 20'h00000, 20'h00000));
    append_row(item_row(OP_DRAW, "z", 1'b0, 20'h00000, 20'h00000));
    append_row(typed_row(OP_CLEAR, "A", 1'b1, 20'h80000, 20'h7FFFF,
                         0, 0, 0, 0, 0, 0));
    append_row(item_row(OP_DRAW, "I", 1'b0, 20'h00000, 20'h00000));
    append_row(item_row(OP_DRAW, "8", 1'b1, 20'h7FFFF, 20'h7FFFF));
    append_row(item_row(OP_DRAW, "M", 1'b1, 20'h80000, 20'h80000));
    append_row(typed_row(OP_DRAW, CH_NEWLINE, 1'b1, 20'hFFFFF, 20'h00000,
                         0, 0, 0, 0, 0, 0));
    append_row(cfg_row(REG_MAX_QUADS, 32'd3));
    append_row(typed_row(OP_DRAW, "8", 1'b0, 20'h00000, 20'h00000,
                         0, 0, 0, 0, 0, 0));
    append_row(typed_row(OP_CLEAR, 8'h00, 1'b0, 20'h00000, 20'h00000,
                         0, 0, 0, 0, 0, 0));
    append_row(item_row(OP_DRAW, "H", 1'b0, 20'h00000, 20'h00000));
    append_row(cfg_row(REG_MAX_QUADS, 32'd0));
    append_row(typed_row(OP_DRAW, "W", 1'b0, 20'h00000, 20'h00000,
                         0, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        cfg_write(plan[i].reg_index, plan[i].reg_value);
        cfg_valid <= 1'b0;
      end else begin
        put_item(plan[i].op, plan[i].ch, plan[i].first, plan[i].sx, plan[i].sy, n);
        if (plan[i].typed) begin
          if (n != plan[i].n_typed) begin
            $error("quad count: expected %0d, actual %0d", plan[i].n_typed, n);
            errors++;
          end else if (n > 0) begin
            pos = pending_quads.size() - n;
            plan[i].first_quad.last_quad = pending_quads[pos].last_quad;
            pending_quads[pos] = plan[i].first_quad;
          end
        end
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin p = 12'd16; d = 12'd14; m = 16'd1024; c = $urandom; end
        1: begin p = 12'd1; d = 12'd1; m = 16'hFFFF; c = 32'h0; end
        2: begin p = 12'hFFF; d = 12'hFFF; m = 16'd300; c = 32'hFFFFFFFF; end
        3: begin
          p = PIX_W'($urandom_range(1, 4095));
          d = (p * 86 / 100 == 0) ? 12'd1 : PIX_W'(p * 86 / 100);
          m = COUNT_W'($urandom_range(20, 400));
          c = $urandom;
        end
        4: begin
          p = PIX_W'($urandom_range(1, 64));
          d = PIX_W'($urandom_range(1, 4095));
          m = 16'd0;
          c = $urandom;
        end
        default: begin
          p = PIX_W'($urandom_range(1, 4095));
          d = PIX_W'($urandom_range(1, 4095));
          m = 16'hFFFF;
          c = $urandom;
        end
      endcase
      settle();
      cfg_write(REG_PIXEL_SIZE, {20'($urandom), p});
      cfg_write(REG_DOT_SIZE, {20'($urandom), d});
      cfg_write(REG_MAX_QUADS, {16'($urandom), m});
      cfg_write(REG_QUAD_COLOR, c);
      cfg_valid <= 1'b0;
      calm      = (ph == 3);
      in_string = 1'b0;
      for (k = 0; k < ((ph == 4) ? 30 : 76); k++) begin
        if (ph == 0 && k == 20) begin
          hold_req <= 1'b1;
        end
        pick   = $urandom_range(99);
        rop    = OP_DRAW;
        rfirst = 1'b0;
        rx     = COORD_W'($urandom);
        ry     = COORD_W'($urandom);
        rch    = charset[$urandom_range(0, charset.len() - 1)];
        if (pick < 4) begin
          rop    = OP_CLEAR;
          rch    = 8'($urandom);
          rfirst = 1'($urandom);
        end else if (pick < 10) begin
          rch    = 8'($urandom);
          rfirst = 1'($urandom);
        end else begin
          if (!in_string || pick >= 94) begin
            rfirst    = 1'b1;
            in_string = 1'b1;
            if ($urandom_range(1) == 1) begin
              rx = COORD_W'($urandom_range(0, 8191));
              ry = COORD_W'($urandom_range(0, 8191));
            end
          end
          if (pick < 18) begin
            rch = CH_NEWLINE;
          end
        end
        put_item(rop, rch, rfirst, rx, ry, n);
      end
    end

    settle();
    if (errors == 0) begin
      $display("text_glyph_quad_generator_top test passed");
    end else begin
      $display("text_glyph_quad_generator_top test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tgqg_pkg.sv
hdl/tgqg_ctrl.sv
hdl/tgqg_datapath.sv
hdl/text_glyph_quad_generator_top.sv
bench/text_glyph_quad_generator_top_test.sv
